// File: rtl/lru_pkg.sv
// Package for the LRU eviction-order tracker: widths, operation codes, shared types.
// No dependencies.
package lru_pkg;
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int OP_W  = 2;
  localparam int KEY_W = 32;
  localparam int OCC_W = 5;

  localparam logic [OP_W-1:0] OP_SET = 2'd0;
  localparam logic [OP_W-1:0] OP_GET = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic             dropped_full;
    logic [OCC_W-1:0] occupancy;
    logic             victim_valid;
    logic [KEY_W-1:0] victim_key;
  } out_word_t;
endpackage

// File: rtl/lru_if.sv
// Valid/ready channel interface carrying one word of type T.
// Depends on lru_pkg for the word types.
interface lru_if #(parameter type T = lru_pkg::in_word_t);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lru_front.sv
// Front part: accepts words and holds them in a two-entry queue for the back part.
// Depends on lru_pkg and lru_if.
module lru_front (
  input  logic  clk,
  input  logic  rst_n,
  lru_if.sink   in_ch,
  lru_if.source q_ch
);
  lru_pkg::in_word_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_ch.valid = (cnt_r != 2'd0);
  assign q_ch.data  = buf_r[rd_r];
  assign pop = q_ch.valid && q_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) buf_r[wr_r] <= in_ch.data;
  end
endmodule

// File: rtl/lru_back.sv
// Back part: parallel key compare in the cycle a word is taken, list shift and result in the next.
// Depends on lru_pkg and lru_if.
module lru_back #(
  parameter int ENTRIES  = lru_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  lru_if.sink   q_ch,
  lru_if.source out_ch
);
  localparam int PW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [KEY_BITS-1:0] list_r [ENTRIES];
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                busy_r;
  logic [lru_pkg::OP_W-1:0] op_r;
  logic [KEY_BITS-1:0] key_r;
  logic                hit_r, hit_c;
  logic [PW-1:0]       pos_r, pos_c;
  logic                ovld_r;
  lru_pkg::out_word_t  out_r, out_nxt;
  logic [KEY_BITS-1:0] key_in;
  logic                take, rm, app, drop;
  logic [KEY_BITS-1:0] list_nxt [ENTRIES];

  assign key_in = KEY_BITS'(q_ch.data.key);
  assign q_ch.ready = !busy_r && (!ovld_r || out_ch.ready);
  assign take = q_ch.valid && q_ch.ready;
  assign out_ch.valid = ovld_r;
  assign out_ch.data  = out_r;

  always_comb begin
    hit_c = 1'b0;
    pos_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (CW'(i) < cnt_r && list_r[i] == key_in) begin
        hit_c = 1'b1;
        pos_c = PW'(i);
      end
    end
  end

  always_comb begin
    rm   = hit_r && (op_r == lru_pkg::OP_SET || op_r == lru_pkg::OP_GET
                     || op_r == lru_pkg::OP_DEL);
    app  = (op_r == lru_pkg::OP_SET || op_r == lru_pkg::OP_GET) && hit_r
        || (op_r == lru_pkg::OP_SET && !hit_r && cnt_r != CW'(ENTRIES));
    drop = op_r == lru_pkg::OP_SET && !hit_r && cnt_r == CW'(ENTRIES);
    cnt_nxt = cnt_r - {{(CW-1){1'b0}}, rm} + {{(CW-1){1'b0}}, app};
    for (int i = 0; i < ENTRIES; i++) begin
      list_nxt[i] = list_r[i];
      if (rm && PW'(i) >= pos_r && i < ENTRIES - 1)
        list_nxt[i] = list_r[(i < ENTRIES - 1) ? i + 1 : i];
      if (app && CW'(i) == cnt_nxt - CW'(1)) list_nxt[i] = key_r;
    end
    out_nxt.found        = hit_r;
    out_nxt.dropped_full = drop;
    out_nxt.occupancy    = lru_pkg::OCC_W'(cnt_nxt);
    out_nxt.victim_valid = (cnt_nxt != '0);
    out_nxt.victim_key   = '0;
    if (cnt_nxt != '0) out_nxt.victim_key = lru_pkg::KEY_W'(list_nxt[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (out_ch.ready) ovld_r <= 1'b0;
      if (take) busy_r <= 1'b1;
      if (busy_r) begin
        busy_r <= 1'b0;
        ovld_r <= 1'b1;
        cnt_r  <= cnt_nxt;
      end
    end
    if (take) begin
      op_r  <= q_ch.data.operation;
      key_r <= key_in;
      hit_r <= hit_c;
      pos_r <= pos_c;
    end
    if (busy_r) begin
      out_r <= out_nxt;
      for (int i = 0; i < ENTRIES; i++) list_r[i] <= list_nxt[i];
    end
  end
endmodule

// File: rtl/lru_eviction_order_tracker_top.sv
// Top level of the LRU eviction-order tracker: front queue plus compare/shift back end.
// Depends on lru_pkg, lru_if, lru_front and lru_back.
// In the back end a parallel key compare against all held entries runs as a word is
// taken; in the next cycle the list shifts and the result is registered, and no new word
// is taken before that. A two-word queue decouples the input; the result register frees
// for the next word in the cycle it is taken. Keys are truncated to KEY_BITS; a set
// of a new key while ENTRIES keys are held is refused and flagged in dropped_full.
module lru_eviction_order_tracker_top #(
  parameter int ENTRIES  = lru_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lru_if.sink   in_ch,
  lru_if.source out_ch
);
  lru_if #(.T(lru_pkg::in_word_t)) q_ch ();

  lru_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_ch  (q_ch.source)
  );

  lru_back #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_ch   (q_ch.sink),
    .out_ch (out_ch)
  );
endmodule
